/* hw/rtl/lbd_pkg.sv */
// Package for the linear blend deinterlacer: register defaults, configuration
// indexes, result beat and push group types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbd_pkg;

  // Line store sizing defaults for the top level parameters
  localparam int MAX_LINE_BYTES_DEF = 4096;
  localparam int MAX_LINES_DEF      = 4096;

  // Configuration port geometry and register reset values
  localparam int CFG_W          = 13;
  localparam int CFG_IDX_W      = 8;
  localparam int LINE_BYTES_RST = 1440;
  localparam int LINE_TOTAL_RST = 576;

  // Smallest frame height that makes sense: first, one blended, last row
  localparam int MIN_LINES = 3;

  // Result queue depth in beats
  localparam int RES_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_BYTES = 8'd0,
    CFG_LINE_TOTAL = 8'd1
  } lbd_cfg_idx_e;

  // One result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_line;
    logic       end_of_frame;
    logic       run_last;
  } lbd_res_t;

  // Up to two result beats pushed in one cycle, first beat in res_a
  typedef struct packed {
    logic [1:0] count;
    lbd_res_t   res_a;
    lbd_res_t   res_b;
  } lbd_push_t;

endpackage

`default_nettype wire

/* hw/rtl/lbd_if.sv */
// Stream interfaces of the deinterlacer: pixel input, result output and
// configuration write channel. Depends on lbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lbd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
  modport mon    (input valid, input pixel_byte, input ready);
endinterface

interface lbd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_line;
  logic       end_of_frame;
  logic       run_last;

  modport source (output valid, output out_byte, output end_of_line,
                  output end_of_frame, output run_last, input ready);
  modport sink   (input valid, input out_byte, input end_of_line,
                  input end_of_frame, input run_last, output ready);
  modport mon    (input valid, input out_byte, input end_of_line,
                  input end_of_frame, input run_last, input ready);
endinterface

interface lbd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lbd_pkg::CFG_IDX_W-1:0] index;
  logic [lbd_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
  modport mon    (input valid, input index, input data, input ready);
endinterface

`default_nettype wire

/* hw/rtl/linear_blend_deinterlacer.sv */
// Top level of the linear blend deinterlacer: counters, line store, blend
// stage and result queue. Depends on lbd_pkg, lbd_if, lbd_ram, lbd_res_fifo.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat content                                   Accept
// pix_i     in   pixel_byte                                     valid && ready
// res_o     out  out_byte, end_of_line, end_of_frame, run_last  valid && ready
// cfg_i     in   index (0 line_bytes, 1 line_total), data       valid && ready
//
// One input beat per cycle while pix_i.ready is high; its results pass the
// line store read register, then the result queue, before they leave.
// Last-row bytes give two result beats, so on the last row the output port,
// at one beat per cycle, sets the pace at which input bytes are taken.
// pix_i.ready drops only when the four-beat result queue cannot take what is
// in flight. cfg_i.ready is always high. No clearing pass after reset.
module linear_blend_deinterlacer #(
  parameter int MAX_LINE_BYTES = lbd_pkg::MAX_LINE_BYTES_DEF,
  parameter int MAX_LINES      = lbd_pkg::MAX_LINES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lbd_pix_if.sink   pix_i,
  lbd_res_if.source res_o,
  lbd_cfg_if.sink   cfg_i
);
  import lbd_pkg::*;

  localparam int CW  = $clog2(MAX_LINE_BYTES);
  localparam int RW  = $clog2(MAX_LINES);
  localparam int EWC = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int EWR = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
  localparam int LW  = $clog2(RES_DEPTH + 1);
  localparam int QW  = LW + 2;

  // Configuration registers
  logic [CFG_W-1:0] line_bytes_q, line_total_q;
  logic             cfg_acc;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q <= CFG_W'(LINE_BYTES_RST);
      line_total_q <= CFG_W'(LINE_TOTAL_RST);
    end else if (cfg_acc) begin
      case (cfg_i.index)
        CFG_LINE_BYTES: line_bytes_q <= cfg_i.data;
        CFG_LINE_TOTAL: line_total_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Clamp the frame geometry to the supported range
  logic [EWC-1:0] lb_ext, eff_w;
  logic [EWR-1:0] lt_ext, eff_h;

  always_comb begin
    lb_ext = EWC'(line_bytes_q);
    lt_ext = EWR'(line_total_q);
    eff_w  = lb_ext;
    if (lb_ext == '0) begin
      eff_w = EWC'(1);
    end else if (lb_ext > EWC'(MAX_LINE_BYTES)) begin
      eff_w = EWC'(MAX_LINE_BYTES);
    end
    eff_h = lt_ext;
    if (lt_ext < EWR'(MIN_LINES)) begin
      eff_h = EWR'(MIN_LINES);
    end else if (lt_ext > EWR'(MAX_LINES)) begin
      eff_h = EWR'(MAX_LINES);
    end
  end

  // Position of the next input byte
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          in_eol, in_last_row, pix_acc;

  assign in_eol      = (EWC'(col_q) + EWC'(1)) >= eff_w;
  assign in_last_row = (EWR'(row_q) + EWR'(1)) >= eff_h;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_acc) begin
      if (in_eol) begin
        col_d = '0;
        row_d = in_last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Blend stage registers, loaded on an accepted beat
  logic          s1_valid_q;
  logic [7:0]    s1_px_q;
  logic [CW-1:0] s1_addr_q;
  logic          s1_eol_q, s1_last_q, s1_row1_q, s1_row2_q;
  logic          fwd_q;
  logic [7:0]    fwd_older_q, fwd_newer_q;
  logic          fwd_hit;

  logic [15:0]   store_rd;
  logic [7:0]    older_eff, newer_eff;
  logic [9:0]    sum;
  lbd_push_t     push;
  lbd_res_t      blend_res, copy_res;
  logic          has_blend;

  // Same column written in the cycle it is read: take the bypass
  assign fwd_hit = s1_valid_q && (s1_addr_q == col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pix_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_px_q     <= pix_i.pixel_byte;
      s1_addr_q   <= col_q;
      s1_eol_q    <= in_eol;
      s1_last_q   <= in_last_row;
      s1_row1_q   <= (row_q == RW'(1));
      s1_row2_q   <= (row_q >= RW'(2));
      fwd_q       <= fwd_hit;
      fwd_older_q <= newer_eff;
      fwd_newer_q <= s1_px_q;
    end
  end

  // Line store: {older_line, newer_line} per column
  lbd_ram #(
    .WIDTH (16),
    .DEPTH (MAX_LINE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i ({newer_eff, s1_px_q}),
    .re_i    (pix_acc),
    .raddr_i (col_q),
    .rdata_o (store_rd)
  );

  // Blend rows above, at and below, or pass the byte through
  always_comb begin
    older_eff = fwd_q ? fwd_older_q : store_rd[15:8];
    newer_eff = fwd_q ? fwd_newer_q : store_rd[7:0];
    sum       = {2'b00, older_eff} + {1'b0, newer_eff, 1'b0} + {2'b00, s1_px_q};
    has_blend = s1_valid_q && (s1_row1_q || s1_row2_q);

    blend_res.out_byte     = s1_row1_q ? newer_eff : sum[9:2];
    blend_res.end_of_line  = s1_eol_q;
    blend_res.end_of_frame = 1'b0;
    blend_res.run_last     = !s1_last_q;

    copy_res.out_byte     = s1_px_q;
    copy_res.end_of_line  = s1_eol_q;
    copy_res.end_of_frame = s1_eol_q;
    copy_res.run_last     = 1'b1;

    push.res_a = blend_res;
    push.res_b = copy_res;
    push.count = 2'd0;
    if (has_blend && s1_last_q) begin
      push.count = 2'd2;
    end else if (has_blend) begin
      push.count = 2'd1;
    end else if (s1_valid_q && s1_last_q) begin
      push.res_a = copy_res;
      push.count = 2'd1;
    end
  end

  // Result queue and output port
  logic [LW-1:0] level;
  logic          res_valid;
  lbd_res_t      head;

  lbd_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (res_o.ready),
    .valid_o (res_valid),
    .head_o  (head),
    .level_o (level)
  );

  assign res_o.valid        = res_valid;
  assign res_o.out_byte     = head.out_byte;
  assign res_o.end_of_line  = head.end_of_line;
  assign res_o.end_of_frame = head.end_of_frame;
  assign res_o.run_last     = head.run_last;

  // Take a beat only if the queue has room for it and the one in flight
  assign pix_i.ready = (QW'(level) + QW'(push.count) + QW'(2)) <= QW'(RES_DEPTH);
  assign pix_acc     = pix_i.valid && pix_i.ready;

endmodule

`default_nettype wire

/* hw/rtl/lbd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/lbd_res_fifo.sv */
// Result queue: takes up to two result beats per cycle, hands out one.
// Depends on lbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbd_res_fifo (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire lbd_pkg::lbd_push_t                    push_i,
  input  wire logic                                  pop_i,
  output logic                                       valid_o,
  output lbd_pkg::lbd_res_t                          head_o,
  output logic [$clog2(lbd_pkg::RES_DEPTH+1)-1:0]    level_o
);
  import lbd_pkg::*;

  localparam int PW = $clog2(RES_DEPTH);
  localparam int LW = $clog2(RES_DEPTH + 1);

  lbd_res_t        slot_q [RES_DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [LW-1:0]   level_q, level_d;
  logic [PW-1:0]   wptr_b;
  logic            do_pop;

  assign do_pop = pop_i && (level_q != '0);
  assign wptr_b = wptr_q + PW'(1);

  // Advance pointers and fill level
  always_comb begin
    wptr_d  = wptr_q + PW'(push_i.count);
    rptr_d  = do_pop ? rptr_q + PW'(1) : rptr_q;
    level_d = level_q + LW'(push_i.count) - LW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

  // Store pushed beats in order
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      slot_q[wptr_q] <= push_i.res_a;
    end
    if (push_i.count == 2'd2) begin
      slot_q[wptr_b] <= push_i.res_b;
    end
  end

  assign valid_o = (level_q != '0);
  assign head_o  = slot_q[rptr_q];
  assign level_o = level_q;

endmodule

`default_nettype wire

/* hw/rtl/lbd_checker.sv */
// Port-level checker for the deinterlacer, bound to the top level.
// Depends on linear_blend_deinterlacer port names only.
`timescale 1ns / 1ps
`default_nettype none

module lbd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       pix_valid_i,
  input wire logic       pix_ready_i,
  input wire logic       res_valid_i,
  input wire logic       res_ready_i,
  input wire logic [7:0] res_byte_i,
  input wire logic       res_eol_i,
  input wire logic       res_eof_i,
  input wire logic       res_last_i
);

  logic seen_in_q;

  // Remember that some input beat has been taken since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_in_q <= 1'b0;
    end else if (pix_valid_i && pix_ready_i) begin
      seen_in_q <= 1'b1;
    end
  end

  // Hold a stalled result beat
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_byte_i)
      && $stable(res_eol_i) && $stable(res_eof_i) && $stable(res_last_i))
    else $error("stalled result beat changed");

  // Frame end is a line end and closes the run of its input beat
  a_eof_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_eof_i |-> res_eol_i && res_last_i)
    else $error("end_of_frame without end_of_line and run_last");

  // No result without an earlier input beat
  a_no_early_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> seen_in_q)
    else $error("result beat before any input beat");

endmodule

bind linear_blend_deinterlacer lbd_checker u_lbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_i.valid),
  .pix_ready_i (pix_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_byte_i  (res_o.out_byte),
  .res_eol_i   (res_o.end_of_line),
  .res_eof_i   (res_o.end_of_frame),
  .res_last_i  (res_o.run_last)
);

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for linear_blend_deinterlacer: streams raster bytes,
// predicts the 1-2-1 line blend and checks every result beat in order.
// Depends on lbd_pkg, lbd_if and the deinterlacer RTL.

module tb;
  import lbd_pkg::*;

  localparam int STORE_DEPTH   = MAX_LINE_BYTES_DEF;
  localparam int LINE_CAP      = MAX_LINES_DEF;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int LATENCY_PAUSE = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'd2;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic clk;
  logic rst_n;

  lbd_pix_if pix_bus ();
  lbd_res_if res_bus ();
  lbd_cfg_if cfg_bus ();

  linear_blend_deinterlacer u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  // Shadow of the block: registers, line stores and raster position
  logic [CFG_W-1:0] line_bytes_reg = CFG_W'(LINE_BYTES_RST);
  logic [CFG_W-1:0] line_total_reg = CFG_W'(LINE_TOTAL_RST);
  logic [7:0]       older_row [STORE_DEPTH];
  logic [7:0]       newer_row [STORE_DEPTH];
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  lbd_res_t    blend_pending [$];
  logic [7:0]  pixel_backlog [$];
  idle_mode_e  idle_mode = IDLE_NONE;
  int          hold_grants = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          bad_beats = 0;
  int unsigned cycle_count = 0;
  logic        pix_took = 1'b0;
  logic        cfg_took = 1'b0;

  function automatic int unsigned eff_bytes(logic [CFG_W-1:0] v);
    if (v < 1) return 1;
    if (v > STORE_DEPTH) return STORE_DEPTH;
    return v;
  endfunction

  function automatic int unsigned eff_lines(logic [CFG_W-1:0] v);
    if (v < MIN_LINES) return MIN_LINES;
    if (v > LINE_CAP) return LINE_CAP;
    return v;
  endfunction

  // Bytes still to come before the raster position wraps to a new frame
  function automatic int unsigned frame_left();
    int unsigned w;
    int unsigned h;
    int unsigned n;
    w = eff_bytes(line_bytes_reg);
    h = eff_lines(line_total_reg);
    n = (col_pos + 1 >= w) ? 1 : w - col_pos;
    if (row_pos + 1 < h) n += (h - 1 - row_pos) * w;
    return n;
  endfunction

  // Work out the beats one source byte causes, then advance the shadow
  function automatic void predict_blend(logic [7:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    logic        eol;
    logic        last_row;
    logic [9:0]  sum;
    lbd_res_t    beat;
    w        = eff_bytes(line_bytes_reg);
    h        = eff_lines(line_total_reg);
    c        = col_pos % STORE_DEPTH;
    eol      = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= h);
    // Row above leaves one behind: copied on row one, blended after that
    if (row_pos >= 1) begin
      sum = {2'b00, older_row[c]} + {1'b0, newer_row[c], 1'b0} + {2'b00, px};
      beat.out_byte     = (row_pos == 1) ? newer_row[c] : sum[9:2];
      beat.end_of_line  = eol;
      beat.end_of_frame = 1'b0;
      beat.run_last     = !last_row;
      blend_pending.push_back(beat);
    end
    // Last row passes its own byte straight through
    if (last_row) begin
      beat.out_byte     = px;
      beat.end_of_line  = eol;
      beat.end_of_frame = eol;
      beat.run_last     = 1'b1;
      blend_pending.push_back(beat);
    end
    older_row[c] = newer_row[c];
    newer_row[c] = px;
    if (eol) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  // Write one register and wait for its beat
  task automatic write_reg(logic [CFG_IDX_W-1:0] reg_idx, logic [CFG_W-1:0] reg_val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= reg_idx;
    cfg_bus.data  <= reg_val;
    do @(negedge clk); while (!cfg_took);
    cfg_bus.valid <= 1'b0;
  endtask

  // Hold until every byte is taken and every beat has come back, then settle
  task automatic drain_block();
    do begin
      @(posedge clk);
      #1;
    end while (pixel_backlog.size() != 0 || (pix_bus.valid && !pix_took) ||
               blend_pending.size() != 0);
    repeat (LATENCY_PAUSE) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Source side: offer the next byte once the current beat has gone
  always @(negedge clk) begin
    if (!rst_n) begin
      pix_bus.valid <= 1'b0;
    end else if (!pix_bus.valid || pix_took) begin
      if (pixel_backlog.size() != 0 &&
          !((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 67) ||
            (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 27))) begin
        pix_bus.valid      <= 1'b1;
        pix_bus.pixel_byte <= pixel_backlog.pop_front();
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus a long hold when one is granted
  always @(negedge clk) begin
    if (hold_grants != hold_seen) begin
      hold_seen = hold_grants;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      case (idle_mode)
        IDLE_RECV: res_bus.ready <= ($urandom_range(0, 99) >= 67);
        IDLE_BOTH: res_bus.ready <= ($urandom_range(0, 99) >= 27);
        default:   res_bus.ready <= 1'b1;
      endcase
    end
  end

  // Sample handshakes, check result beats, advance the shadow
  always @(posedge clk) begin
    lbd_res_t want;
    cycle_count <= cycle_count + 1;
    pix_took    <= rst_n && pix_bus.valid && pix_bus.ready;
    cfg_took    <= rst_n && cfg_bus.valid && cfg_bus.ready;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (blend_pending.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("unexpected beat: byte %0d eol %0d eof %0d last %0d",
                   res_bus.out_byte, res_bus.end_of_line, res_bus.end_of_frame,
                   res_bus.run_last);
      end else begin
        want = blend_pending.pop_front();
        if (res_bus.out_byte !== want.out_byte ||
            res_bus.end_of_line !== want.end_of_line ||
            res_bus.end_of_frame !== want.end_of_frame ||
            res_bus.run_last !== want.run_last) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("beat mismatch: expected byte %0d eol %0d eof %0d last %0d, got %0d %0d %0d %0d",
                     want.out_byte, want.end_of_line, want.end_of_frame, want.run_last,
                     res_bus.out_byte, res_bus.end_of_line, res_bus.end_of_frame,
                     res_bus.run_last);
        end
      end
    end
    if (rst_n && pix_bus.valid && pix_bus.ready) predict_blend(pix_bus.pixel_byte);
    if (rst_n && cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_bus.index)
        CFG_LINE_BYTES: line_bytes_reg = cfg_bus.data;
        CFG_LINE_TOTAL: line_total_reg = cfg_bus.data;
        default: ;
      endcase
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("linear_blend_deinterlacer test failed");
      $finish;
    end
  end

  initial begin
    int unsigned random_sent;
    int unsigned phase_no;
    int unsigned kind;
    int unsigned len;
    int unsigned cur_w;
    int unsigned new_w;
    int unsigned new_h;
    logic        at_start;
    logic        pressure;
    pix_bus.valid      = 1'b0;
    pix_bus.pixel_byte = 8'd0;
    res_bus.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = CFG_LINE_BYTES;
    cfg_bus.data       = '0;
    rst_n              = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Start of a wide row at the reset geometry: no output yet
    @(posedge clk);
    pixel_backlog = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd254, 8'd127};
    drain_block();

    // Shrink the line mid-row: column past the end closes the row
    write_reg(CFG_LINE_BYTES, 13'd4);
    write_reg(CFG_LINE_TOTAL, 13'd3);
    @(posedge clk);
    pixel_backlog = '{8'd17, 8'd255, 8'd255, 8'd0, 8'd255,
                      8'd255, 8'd255, 8'd0, 8'd1};
    drain_block();

    // Single byte lines
    write_reg(CFG_LINE_BYTES, 13'd1);
    write_reg(CFG_LINE_TOTAL, 13'd3);
    @(posedge clk);
    pixel_backlog = '{8'd255, 8'd255, 8'd0};
    drain_block();

    // Out of range geometry clamps; unknown register is dropped
    write_reg(CFG_LINE_BYTES, 13'd0);
    write_reg(CFG_LINE_TOTAL, 13'd2);
    write_reg(CFG_IDX_UNUSED, 13'h1fff);
    @(posedge clk);
    pixel_backlog = '{8'd200, 8'd100, 8'd50};
    drain_block();

    // Random phases; the line only grows at a frame boundary so that
    // every store entry read was written in the current frame
    random_sent = 0;
    phase_no    = 0;
    while (random_sent < RANDOM_ITEMS) begin
      at_start  = (row_pos == 0 && col_pos == 0);
      cur_w     = eff_bytes(line_bytes_reg);
      pressure  = (phase_no == 3 || phase_no == 12);
      idle_mode = idle_mode_e'(phase_no % 4);
      kind      = pressure ? 5 : $urandom_range(0, 9);
      len       = $urandom_range(5, 80);
      if (kind == 0 && at_start) begin
        // widest line, cut short by a later shrink
        write_reg(CFG_LINE_BYTES, $urandom_range(0, 1) ? 13'd4096 : 13'h1fff);
        write_reg(CFG_LINE_TOTAL, CFG_W'($urandom_range(3, 5)));
        len = $urandom_range(10, 40);
      end else if (kind == 1) begin
        // tallest frame, later cut short by a height write
        write_reg(CFG_LINE_BYTES, 13'd1);
        write_reg(CFG_LINE_TOTAL, $urandom_range(0, 1) ? 13'd4096 :
                                  CFG_W'($urandom_range(4097, 8191)));
        len = $urandom_range(10, 50);
      end else begin
        if (kind == 2) begin
          write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_W'($urandom_range(0, 8191)));
          new_h = $urandom_range(0, 2);
        end else begin
          new_h = $urandom_range(3, 7);
        end
        new_w = $urandom_range(1, 12);
        if (!at_start && new_w > cur_w) new_w = cur_w;
        write_reg(CFG_LINE_BYTES, CFG_W'(new_w));
        write_reg(CFG_LINE_TOTAL, CFG_W'(new_h));
        if ($urandom_range(0, 1) && frame_left() <= 400) len = frame_left();
      end
      // Hold the output while bytes keep coming so the input backs up
      if (pressure) begin
        idle_mode = IDLE_NONE;
        len       = 150;
        hold_grants++;
      end
      @(posedge clk);
      repeat (len) pixel_backlog.push_back(8'($urandom_range(0, 255)));
      random_sent += len;
      phase_no++;
      drain_block();
    end

    repeat (20) @(posedge clk);
    if (bad_beats == 0 && blend_pending.size() == 0) begin
      $display("linear_blend_deinterlacer test passed");
    end else begin
      $display("linear_blend_deinterlacer test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/lbd_pkg.sv
hw/rtl/lbd_if.sv
hw/rtl/lbd_ram.sv
hw/rtl/lbd_res_fifo.sv
hw/rtl/linear_blend_deinterlacer.sv
hw/rtl/lbd_checker.sv
tb/sv/tb.sv
